@@ hw/rtl/phh2d_pkg.sv @@
// Shared types and constants for the plate hit histogram.
`timescale 1ns / 1ps
package phh2d_pkg;

	localparam int PLATE_W    = 3;
	localparam int POS_W      = 32;
	localparam int SCALE_W    = 32;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 3;
	localparam int CNT_W      = 32;
	localparam int BIN_OUT_W  = 6;
	localparam int NUM_PLATES = 6;
	localparam int FIFO_DEPTH = 4;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// Configuration register indexes.
	localparam cfg_idx_t REG_PLATE1_SCALE = 3'd0;
	localparam cfg_idx_t REG_PLATE6_SCALE = 3'd5;
	localparam cfg_idx_t REG_BIN_OFFSET   = 3'd6;

	localparam logic [CFG_DATA_W-1:0] SCALE_RESET  = 64'h0001_0000_0001_0000;
	localparam logic [POS_W-1:0]      OFFSET_RESET = 32'h0020_0000;
	localparam logic [CNT_W-1:0]      CNT_MAX      = '1;

	typedef struct packed {
		logic                 accepted;
		logic [BIN_OUT_W-1:0] bin_h;
		logic [BIN_OUT_W-1:0] bin_v;
		logic [CNT_W-1:0]     bin_count;
		logic [CNT_W-1:0]     plate_peak;
		logic [CNT_W-1:0]     plate_total;
	} res_t;

endpackage

@@ hw/rtl/phh2d_hit_if.sv @@
// Hit channel: valid/ready handshake with plate number and position pair.
`timescale 1ns / 1ps
interface phh2d_hit_if;
	import phh2d_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [PLATE_W-1:0]      plate;
	logic signed [POS_W-1:0] pos_h;
	logic signed [POS_W-1:0] pos_v;

	modport source (output valid, output plate, output pos_h, output pos_v, input ready);
	modport sink   (input valid, input plate, input pos_h, input pos_v, output ready);
endinterface

@@ hw/rtl/phh2d_res_if.sv @@
// Result channel: valid/ready handshake with the per-hit histogram report.
`timescale 1ns / 1ps
interface phh2d_res_if;
	import phh2d_pkg::*;

	logic                 valid;
	logic                 ready;
	logic                 accepted;
	logic [BIN_OUT_W-1:0] bin_h;
	logic [BIN_OUT_W-1:0] bin_v;
	logic [CNT_W-1:0]     bin_count;
	logic [CNT_W-1:0]     plate_peak;
	logic [CNT_W-1:0]     plate_total;

	modport source (output valid, output accepted, output bin_h, output bin_v,
		output bin_count, output plate_peak, output plate_total, input ready);
	modport sink (input valid, input accepted, input bin_h, input bin_v,
		input bin_count, input plate_peak, input plate_total, output ready);
endinterface

@@ hw/rtl/phh2d_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
module phh2d_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hw/rtl/phh2d_binner.sv @@
// One axis of the binning datapath: scale multiply, offset add, floor and grid check.
`timescale 1ns / 1ps
module phh2d_binner #(
	parameter int GRID = 64
) (
	input  logic                                clk,
	input  logic signed [phh2d_pkg::POS_W-1:0]  pos,
	input  logic [phh2d_pkg::SCALE_W-1:0]       scale,
	input  logic [phh2d_pkg::POS_W-1:0]         offset,
	output logic                                in_grid_s3,
	output logic [$clog2(GRID)-1:0]             bin_s3
);
	import phh2d_pkg::*;

	localparam int BIN_W = $clog2(GRID);

	logic signed [SCALE_W:0]         scale_sx;
	logic signed [POS_W+SCALE_W:0]   prod;
	logic [POS_W+SCALE_W-1:0]        prod_s2;
	logic [POS_W+SCALE_W:0]          sum;
	logic [POS_W:0]                  ipart;

	// Exact signed Q32.32 product; the scale is unsigned, so it gets a zero sign bit.
	always_comb begin
		scale_sx = $signed({1'b0, scale});
		prod     = pos * scale_sx;
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod[POS_W+SCALE_W-1:0];
	end

	// Offset widened to Q32.32; the integer part of the sum is the floor.
	always_comb begin
		sum   = {prod_s2[POS_W+SCALE_W-1], prod_s2}
			+ {{(SCALE_W-16+1){offset[POS_W-1]}}, offset, 16'h0000};
		ipart = sum[POS_W+SCALE_W:SCALE_W];
	end

	always_ff @(posedge clk) begin
		in_grid_s3 <= !ipart[POS_W] && (ipart != '0) && (ipart <= (POS_W+1)'(GRID));
		bin_s3     <= BIN_W'(ipart - (POS_W+1)'(1));
	end

endmodule

@@ hw/rtl/plate_hit_histogram_2d.sv @@
// Top level of the six-plate two-dimensional hit histogram with peak tracking.
`timescale 1ns / 1ps
// Datapath: a hit passes stages 1 to 4, then its result is written to the result FIFO and offered.
// Flow: each hit holds one of four result FIFO slots from its transfer until its result is
// delivered; the count RAM read-modify-write forwards between adjacent hits.
// Reset: after arst_n releases, a clearing pass zeroes every count RAM entry;
// no hit is taken until it finishes.
module plate_hit_histogram_2d #(
	parameter int GRID = 64
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [phh2d_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [phh2d_pkg::CFG_DATA_W-1:0]     cfg_data,
	phh2d_hit_if.sink                            hit,
	phh2d_res_if.source                          result
);
	import phh2d_pkg::*;

	localparam int BIN_W   = $clog2(GRID);
	localparam int DEPTH   = NUM_PLATES * GRID * GRID;
	localparam int AW      = $clog2(DEPTH);
	localparam int PTR_W   = $clog2(FIFO_DEPTH);
	localparam int PEND_W  = $clog2(FIFO_DEPTH + 1);
	localparam logic [AW-1:0] PLATE_STRIDE = AW'(GRID * GRID);
	localparam logic [AW-1:0] ROW_STRIDE   = AW'(GRID);
	localparam logic [AW-1:0] LAST_ADDR    = AW'(DEPTH - 1);

	// Configuration registers. Write only while the block is idle; the block does not check.
	logic [CFG_DATA_W-1:0] scale_q [NUM_PLATES];
	logic [POS_W-1:0]      offset_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PLATES; i++) begin
				scale_q[i] <= SCALE_RESET;
			end
			offset_q <= OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index) inside
				[REG_PLATE1_SCALE:REG_PLATE6_SCALE]: scale_q[cfg_index] <= cfg_data;
				REG_BIN_OFFSET: offset_q <= cfg_data[POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Clearing pass over the count RAM right after reset.
	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == LAST_ADDR) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// Flow control: every hit taken owns a slot in the result FIFO, so the
	// pipeline never has to stall. pending_q counts hits taken but not yet delivered.
	logic              hit_xfer;
	logic              res_xfer;
	logic [PEND_W-1:0] pending_q;

	assign hit.ready = !clr_busy_q && (pending_q < PEND_W'(FIFO_DEPTH));
	assign hit_xfer  = hit.valid && hit.ready;
	assign res_xfer  = result.valid && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (hit_xfer && !res_xfer) begin
			pending_q <= pending_q + PEND_W'(1);
		end else if (!hit_xfer && res_xfer) begin
			pending_q <= pending_q - PEND_W'(1);
		end
	end

	// Stage 1: register the hit together with its plate's scale pair.
	logic                    plate_ok;
	logic [PLATE_W-1:0]      pidx;
	logic                    vld_s1, vld_s2, vld_s3, vld_s4;
	logic                    pok_s1, pok_s2, pok_s3, pok_s4;
	logic [PLATE_W-1:0]      pidx_s1, pidx_s2, pidx_s3, pidx_s4;
	logic signed [POS_W-1:0] pos_h_s1, pos_v_s1;
	logic [CFG_DATA_W-1:0]   scale_s1;

	assign plate_ok = (hit.plate >= PLATE_W'(1)) && (hit.plate <= PLATE_W'(NUM_PLATES));
	assign pidx     = plate_ok ? hit.plate - PLATE_W'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= hit_xfer;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		pos_h_s1 <= hit.pos_h;
		pos_v_s1 <= hit.pos_v;
		scale_s1 <= scale_q[pidx];
		pok_s1   <= plate_ok;
		pidx_s1  <= pidx;
		pok_s2   <= pok_s1;
		pidx_s2  <= pidx_s1;
		pok_s3   <= pok_s2;
		pidx_s3  <= pidx_s2;
	end

	// Stages 2 and 3: one binning unit per axis, multiply then add and check.
	logic             grid_h_s3, grid_v_s3;
	logic [BIN_W-1:0] bin_h_s3, bin_v_s3;

	phh2d_binner #(.GRID(GRID)) u_bin_h (
		.clk        (clk),
		.pos        (pos_h_s1),
		.scale      (scale_s1[CFG_DATA_W-1:SCALE_W]),
		.offset     (offset_q),
		.in_grid_s3 (grid_h_s3),
		.bin_s3     (bin_h_s3)
	);

	phh2d_binner #(.GRID(GRID)) u_bin_v (
		.clk        (clk),
		.pos        (pos_v_s1),
		.scale      (scale_s1[SCALE_W-1:0]),
		.offset     (offset_q),
		.in_grid_s3 (grid_v_s3),
		.bin_s3     (bin_v_s3)
	);

	// Stage 3 issues the count RAM read; the data lines up with stage 4.
	logic [AW-1:0]    rd_addr;
	logic [AW-1:0]    addr_s4;
	logic             rng_s4;
	logic [BIN_W-1:0] bin_h_s4, bin_v_s4;

	assign rd_addr = AW'(pidx_s3) * PLATE_STRIDE + AW'(bin_h_s3) * ROW_STRIDE + AW'(bin_v_s3);

	always_ff @(posedge clk) begin
		addr_s4  <= rd_addr;
		rng_s4   <= grid_h_s3 && grid_v_s3;
		bin_h_s4 <= bin_h_s3;
		bin_v_s4 <= bin_v_s3;
		pok_s4   <= pok_s3;
		pidx_s4  <= pidx_s3;
	end

	// Stage 4: modify and write back. A hit read its entry in the same cycle
	// the previous hit wrote it, so the previous write is forwarded on a match.
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic [CNT_W-1:0] ram_rdata;
	logic             count_hit;
	logic [CNT_W-1:0] old_cnt, new_cnt, new_total, new_peak;
	logic             fwd_vld_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [CNT_W-1:0] fwd_data_q;
	logic [CNT_W-1:0] total_q [NUM_PLATES];
	logic [CNT_W-1:0] peak_q  [NUM_PLATES];
	res_t             res_d;

	assign count_hit = vld_s4 && pok_s4 && rng_s4;

	always_comb begin
		old_cnt   = (fwd_vld_q && (fwd_addr_q == addr_s4)) ? fwd_data_q : ram_rdata;
		new_cnt   = (old_cnt == CNT_MAX) ? old_cnt : old_cnt + CNT_W'(1);
		new_total = (total_q[pidx_s4] == CNT_MAX) ? total_q[pidx_s4]
			: total_q[pidx_s4] + CNT_W'(1);
		new_peak  = (peak_q[pidx_s4] < new_cnt) ? new_cnt : peak_q[pidx_s4];
	end

	assign ram_we    = clr_busy_q || count_hit;
	assign ram_waddr = clr_busy_q ? clr_addr_q : addr_s4;
	assign ram_wdata = clr_busy_q ? '0 : new_cnt;

	phh2d_ram #(.WIDTH(CNT_W), .DEPTH(DEPTH)) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
			for (int i = 0; i < NUM_PLATES; i++) begin
				total_q[i] <= '0;
				peak_q[i]  <= '0;
			end
		end else begin
			fwd_vld_q <= count_hit;
			if (count_hit) begin
				total_q[pidx_s4] <= new_total;
				peak_q[pidx_s4]  <= new_peak;
			end
		end
	end

	always_ff @(posedge clk) begin
		fwd_addr_q <= addr_s4;
		fwd_data_q <= new_cnt;
	end

	// Report: a hit on an invalid plate reports all zero; a hit off the grid
	// reports only the plate's current peak and total.
	always_comb begin
		res_d = '0;
		if (count_hit) begin
			res_d.accepted    = 1'b1;
			res_d.bin_h       = BIN_OUT_W'(bin_h_s4);
			res_d.bin_v       = BIN_OUT_W'(bin_v_s4);
			res_d.bin_count   = new_cnt;
			res_d.plate_peak  = new_peak;
			res_d.plate_total = new_total;
		end else if (pok_s4) begin
			res_d.plate_peak  = peak_q[pidx_s4];
			res_d.plate_total = total_q[pidx_s4];
		end
	end

	// Result FIFO: decouples the fixed-latency pipeline from the sink.
	res_t              fifo_q [FIFO_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [PEND_W-1:0] fifo_cnt_q;
	res_t              head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
		end else begin
			if (vld_s4) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (res_xfer) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			if (vld_s4 && !res_xfer) begin
				fifo_cnt_q <= fifo_cnt_q + PEND_W'(1);
			end else if (!vld_s4 && res_xfer) begin
				fifo_cnt_q <= fifo_cnt_q - PEND_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s4) begin
			fifo_q[wr_ptr_q] <= res_d;
		end
	end

	assign head               = fifo_q[rd_ptr_q];
	assign result.valid       = (fifo_cnt_q != '0);
	assign result.accepted    = head.accepted;
	assign result.bin_h       = head.bin_h;
	assign result.bin_v       = head.bin_v;
	assign result.bin_count   = head.bin_count;
	assign result.plate_peak  = head.plate_peak;
	assign result.plate_total = head.plate_total;

	// The FIFO can never be asked to hold more than it has slots for.
	a_pending_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(pending_q <= PEND_W'(FIFO_DEPTH)) && (fifo_cnt_q <= pending_q))
		else $error("result FIFO occupancy exceeds outstanding hits");

	// No hit may enter while the count RAM is still being cleared.
	a_no_hit_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !hit.ready)
		else $error("hit taken during clearing pass");

	// A counted hit always reports a nonzero count no larger than the plate peak.
	a_count_vs_peak: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.accepted) |->
		(result.bin_count != '0) && (result.bin_count <= result.plate_peak))
		else $error("bin count inconsistent with plate peak");

	// Every hit taken reaches stage 4 through stages 1 to 3.
	a_pipe_latency: assert property (@(posedge clk) disable iff (!arst_n)
		hit_xfer |-> ##4 vld_s4)
		else $error("pipeline lost a hit");

endmodule
